### hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define LSM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("layer stack check failed");

// Clocked assertion that also holds during reset.
`define LSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("layer stack check failed");

`endif

### hdl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Types and codes shared by the layer stack manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

  localparam int MAX_LAYERS_DEF = 256;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;

  localparam logic [11:0] SCREEN_W_RST = 12'd320;
  localparam logic [11:0] SCREEN_H_RST = 12'd200;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_SIZE    = 3'd1;
  localparam logic [2:0] REQ_HEIGHT  = 3'd2;
  localparam logic [2:0] REQ_MOVE    = 3'd3;
  localparam logic [2:0] REQ_REPAINT = 3'd4;
  localparam logic [2:0] REQ_FREE    = 3'd5;

  localparam logic [1:0] CMD_ACK     = 2'd0;
  localparam logic [1:0] CMD_REBUILD = 2'd1;
  localparam logic [1:0] CMD_REDRAW  = 2'd2;
  localparam logic [1:0] CMD_ALLOC   = 2'd3;

  typedef struct packed {
    logic signed [8:0]  height;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [10:0]        w;
    logic [10:0]        h;
  } layer_rec_t;

  typedef struct packed {
    logic height;
    logic pos;
    logic size;
  } layer_we_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [12:0] x0;
    logic signed [12:0] y0;
    logic signed [12:0] x1;
    logic signed [12:0] y1;
    logic signed [8:0]  lo;
    logic signed [8:0]  hi;
    logic [7:0]         id;
    logic               ok;
    logic               last;
  } cmd_desc_t;

endpackage

`default_nettype wire

### hdl/lsm_order_mem.sv
// ----------------------------------------------------------------------------
// lsm_order_mem
// Stacking order table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_order_mem #(
  parameter int DEPTH = lsm_pkg::MAX_LAYERS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/lsm_layer_mem.sv
// ----------------------------------------------------------------------------
// lsm_layer_mem
// Per-layer records (height, position, size) with a write enable per field
// group and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_layer_mem #(
  parameter int DEPTH = lsm_pkg::MAX_LAYERS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire lsm_pkg::layer_we_t we,
  input  wire logic [AW-1:0]      waddr,
  input  wire lsm_pkg::layer_rec_t wdata,
  input  wire logic [AW-1:0]      raddr,
  output lsm_pkg::layer_rec_t     rdata
);

  logic signed [8:0]  height_mem [DEPTH];
  logic signed [11:0] x_mem [DEPTH];
  logic signed [11:0] y_mem [DEPTH];
  logic [10:0]        w_mem [DEPTH];
  logic [10:0]        h_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.height) begin
      height_mem[waddr] <= wdata.height;
    end
    if (we.pos) begin
      x_mem[waddr] <= wdata.x;
      y_mem[waddr] <= wdata.y;
    end
    if (we.size) begin
      w_mem[waddr] <= wdata.w;
      h_mem[waddr] <= wdata.h;
    end
    rdata.height <= height_mem[raddr];
    rdata.x      <= x_mem[raddr];
    rdata.y      <= y_mem[raddr];
    rdata.w      <= w_mem[raddr];
    rdata.h      <= h_mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/lsm_emit.sv
// ----------------------------------------------------------------------------
// lsm_emit
// Result stage: clips command rectangles to the screen and registers the
// result ports for every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire lsm_pkg::cmd_desc_t desc,
  input  wire logic [11:0]        screen_w,
  input  wire logic [11:0]        screen_h,
  output logic                    strobe,
  output logic [1:0]              cmd_kind,
  output logic [11:0]             rect_x0,
  output logic [11:0]             rect_y0,
  output logic [11:0]             rect_x1,
  output logic [11:0]             rect_y1,
  output logic signed [8:0]       layer_low,
  output logic signed [8:0]       layer_high,
  output logic [7:0]              layer_out,
  output logic                    ok,
  output logic                    last
);

  function automatic logic [11:0] clampc(input logic signed [12:0] v,
                                         input logic [11:0] lim);
    logic [11:0] r;
    if (v < 13'sd0) begin
      r = '0;
    end else if (v > $signed({1'b0, lim})) begin
      r = lim;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  logic [11:0] cx0, cy0, cx1, cy1;
  logic        has_rect;

  always_comb begin
    has_rect = (desc.kind == lsm_pkg::CMD_REBUILD) || (desc.kind == lsm_pkg::CMD_REDRAW);
    cx0 = '0;
    cy0 = '0;
    cx1 = '0;
    cy1 = '0;
    if (has_rect) begin
      cx0 = clampc(desc.x0, screen_w);
      cy0 = clampc(desc.y0, screen_h);
      cx1 = clampc(desc.x1, screen_w);
      cy1 = clampc(desc.y1, screen_h);
      // An inverted edge collapses onto the opposite one.
      if (cx1 < cx0) begin
        cx1 = cx0;
      end
      if (cy1 < cy0) begin
        cy1 = cy0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= en;
    end
    if (en) begin
      cmd_kind   <= desc.kind;
      rect_x0    <= cx0;
      rect_y0    <= cy0;
      rect_x1    <= cx1;
      rect_y1    <= cy1;
      layer_low  <= desc.lo;
      layer_high <= desc.hi;
      layer_out  <= desc.id;
      ok         <= desc.ok;
      last       <= desc.last;
    end
  end

endmodule

`default_nettype wire

### hdl/layer_stack_manager_top.sv
// ----------------------------------------------------------------------------
// layer_stack_manager_top
// Display layer pool with stacking order and repaint command generation.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken when start is high and busy is low. The block
//   then works on that request alone and drives busy until its last result
//   has been registered. Results leave as beats on strobe, one per cycle,
//   back to back, with last on the final one; the receiver cannot stall
//   them. Configuration writes (screen width and height) are taken on
//   cfg_valid at any time (cfg_ready is always high) and should only be
//   issued while the block is idle.
// Request flow:
//   Layer records live in a memory with registered reads, so a valid
//   request other than an allocation reads its record in a read state
//   before its result beats. Allocation scans the free bits one layer a
//   cycle. A height change shifts the order table one entry a cycle
//   through its single write port before its result beats.
// Reset:
//   Synchronous reset frees every layer, empties the stack and restores the
//   default screen size. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_stack_manager_top #(
  parameter int MAX_LAYERS = lsm_pkg::MAX_LAYERS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   req_type,
  input  wire logic [7:0]                   sheet_id,
  input  wire logic signed [9:0]            new_height,
  input  wire logic signed [11:0]           pos_x,
  input  wire logic signed [11:0]           pos_y,
  input  wire logic [10:0]                  size_x,
  input  wire logic [10:0]                  size_y,
  input  wire logic signed [11:0]           area_x0,
  input  wire logic signed [11:0]           area_y0,
  input  wire logic signed [11:0]           area_x1,
  input  wire logic signed [11:0]           area_y1,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [11:0]                  cfg_data,
  output logic                              strobe,
  output logic [1:0]                        cmd_kind,
  output logic [11:0]                       rect_x0,
  output logic [11:0]                       rect_y0,
  output logic [11:0]                       rect_x1,
  output logic [11:0]                       rect_y1,
  output logic signed [8:0]                 layer_low,
  output logic signed [8:0]                 layer_high,
  output logic [7:0]                        layer_out,
  output logic                              ok,
  output logic                              last
);

  localparam int LW = $clog2(MAX_LAYERS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    P_ACK,
    P_ALLOC,
    P_MOVE,
    P_REPAINT,
    P_LOWER,
    P_HIDE,
    P_RAISE
  } plan_t;

  state_t state;
  plan_t  plan;
  logic   plan_ok;
  logic [2:0] n_res;
  logic [1:0] e_idx;

  logic [11:0] screen_w, screen_h;
  logic [MAX_LAYERS-1:0] in_use, rec_vld;
  logic signed [8:0] top_height;

  // Request payload.
  logic [2:0]         r_kind;
  logic [LW-1:0]      r_id;
  logic signed [9:0]  r_nh;
  logic signed [11:0] r_px, r_py, r_ax0, r_ay0, r_ax1, r_ay1;
  logic [10:0]        r_sx, r_sy;
  logic               pv;

  // Layer record captured at the read.
  logic signed [11:0] lx, ly;
  logic [10:0]        lw, lh;
  logic signed [8:0]  ht, hnew;

  logic [LW-1:0] scan, alloc_id;
  logic [LW-1:0] sh_dst, sh_wdst;
  logic [LW:0]   sh_cnt;
  logic          sh_up, sh_pend;

  // Memory ports.
  lsm_pkg::layer_we_t  lm_we;
  lsm_pkg::layer_rec_t lm_wdata, lm_rdata;
  logic [LW-1:0]       lm_waddr, lm_raddr;
  logic                om_we;
  logic [LW-1:0]       om_waddr, om_wdata, om_raddr, om_rdata;

  lsm_pkg::cmd_desc_t desc;

  // Height clamp and shift plan, evaluated in the read cycle.
  logic signed [9:0] lim10, tgt10, hc10, ht10, top10;
  logic signed [8:0] cur_h;
  logic              id_ok, req_ok;
  logic [LW-1:0]     sel;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign sel       = sheet_id[LW-1:0];
  assign id_ok     = ({1'b0, sheet_id} < 9'(MAX_LAYERS));
  assign req_ok    = (req_type <= lsm_pkg::REQ_FREE) && id_ok && in_use[sel];

  always_comb begin
    cur_h = lm_rdata.height;
    ht10  = 10'(cur_h);
    top10 = 10'(top_height);
    lim10 = (cur_h >= 9'sd0) ? top10 : top10 + 10'sd1;
    tgt10 = (r_kind == lsm_pkg::REQ_FREE) ? -10'sd1 : r_nh;
    hc10  = (tgt10 > lim10) ? lim10 : tgt10;
    if (hc10 < -10'sd1) begin
      hc10 = -10'sd1;
    end
  end

  // Memory port control.
  always_comb begin
    lm_we    = '0;
    lm_waddr = r_id;
    lm_wdata = '0;
    lm_raddr = sel;
    om_we    = 1'b0;
    om_waddr = sh_wdst;
    om_wdata = om_rdata;
    om_raddr = sh_up ? sh_dst + LW'(1) : sh_dst - LW'(1);
    case (state)
      S_READ: begin
        case (r_kind)
          lsm_pkg::REQ_SIZE: begin
            // The first write of a record also zeroes the other field group.
            lm_we.size = 1'b1;
            lm_we.pos  = !pv;
            lm_wdata.w = r_sx;
            lm_wdata.h = r_sy;
          end
          lsm_pkg::REQ_MOVE: begin
            lm_we.pos  = 1'b1;
            lm_we.size = !pv;
            lm_wdata.x = r_px;
            lm_wdata.y = r_py;
          end
          lsm_pkg::REQ_HEIGHT, lsm_pkg::REQ_FREE: begin
            lm_we.height    = (hc10 != ht10);
            lm_wdata.height = hc10[8:0];
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        lm_we.height    = !in_use[scan];
        lm_waddr        = scan;
        lm_wdata.height = -9'sd1;
      end
      S_SHIFT: begin
        if (sh_pend) begin
          // Move one entry and renumber the layer that it holds.
          om_we           = 1'b1;
          lm_we.height    = 1'b1;
          lm_waddr        = om_rdata;
          lm_wdata.height = 9'(sh_wdst);
        end else if (sh_cnt == '0 && hnew >= 9'sd0) begin
          om_we    = 1'b1;
          om_waddr = LW'(hnew);
          om_wdata = r_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      screen_w   <= lsm_pkg::SCREEN_W_RST;
      screen_h   <= lsm_pkg::SCREEN_H_RST;
      in_use     <= '0;
      rec_vld    <= '0;
      top_height <= -9'sd1;
      sh_pend    <= 1'b0;
      sh_cnt     <= '0;
      e_idx      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lsm_pkg::CFG_SCREEN_W: screen_w <= cfg_data;
          lsm_pkg::CFG_SCREEN_H: screen_h <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          e_idx <= '0;
          if (start) begin
            r_kind <= req_type;
            r_id   <= sel;
            r_nh   <= new_height;
            r_px   <= pos_x;
            r_py   <= pos_y;
            r_sx   <= size_x;
            r_sy   <= size_y;
            r_ax0  <= area_x0;
            r_ay0  <= area_y0;
            r_ax1  <= area_x1;
            r_ay1  <= area_y1;
            pv     <= rec_vld[sel];
            if (req_type == lsm_pkg::REQ_ALLOC) begin
              scan  <= '0;
              state <= S_SCAN;
            end else if (!req_ok) begin
              plan    <= P_ACK;
              plan_ok <= 1'b0;
              n_res   <= 3'd1;
              state   <= S_EMIT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // Position and size read as zero until first written.
          lx      <= pv ? lm_rdata.x : '0;
          ly      <= pv ? lm_rdata.y : '0;
          lw      <= pv ? lm_rdata.w : '0;
          lh      <= pv ? lm_rdata.h : '0;
          ht      <= cur_h;
          hnew    <= hc10[8:0];
          plan    <= P_ACK;
          plan_ok <= 1'b1;
          n_res   <= 3'd1;
          state   <= S_EMIT;
          case (r_kind)
            lsm_pkg::REQ_SIZE: begin
              rec_vld[r_id] <= 1'b1;
            end
            lsm_pkg::REQ_MOVE: begin
              rec_vld[r_id] <= 1'b1;
              if (cur_h >= 9'sd0) begin
                plan  <= P_MOVE;
                n_res <= 3'd4;
              end
            end
            lsm_pkg::REQ_REPAINT: begin
              if (cur_h >= 9'sd0) begin
                plan <= P_REPAINT;
              end
            end
            lsm_pkg::REQ_HEIGHT, lsm_pkg::REQ_FREE: begin
              if (r_kind == lsm_pkg::REQ_FREE) begin
                in_use[r_id] <= 1'b0;
              end
              if (hc10 != ht10) begin
                n_res  <= 3'd2;
                state  <= S_SHIFT;
                sh_dst <= LW'(cur_h);
                if (ht10 > hc10) begin
                  if (hc10 >= 10'sd0) begin
                    plan   <= P_LOWER;
                    sh_up  <= 1'b0;
                    sh_cnt <= (LW+1)'(ht10 - hc10);
                  end else begin
                    plan       <= P_HIDE;
                    sh_up      <= 1'b1;
                    sh_cnt     <= (LW+1)'(top10 - ht10);
                    top_height <= top_height - 9'sd1;
                  end
                end else begin
                  plan <= P_RAISE;
                  if (ht10 >= 10'sd0) begin
                    sh_up  <= 1'b1;
                    sh_cnt <= (LW+1)'(hc10 - ht10);
                  end else begin
                    sh_up      <= 1'b0;
                    sh_dst     <= LW'(top10 + 10'sd1);
                    sh_cnt     <= (LW+1)'(top10 + 10'sd1 - hc10);
                    top_height <= top_height + 9'sd1;
                  end
                end
              end
            end
            default: begin
              plan_ok <= 1'b0;
            end
          endcase
        end
        S_SCAN: begin
          plan     <= P_ALLOC;
          n_res    <= 3'd1;
          alloc_id <= scan;
          if (!in_use[scan]) begin
            in_use[scan] <= 1'b1;
            plan_ok      <= 1'b1;
            state        <= S_EMIT;
          end else if (scan == LW'(MAX_LAYERS - 1)) begin
            plan_ok  <= 1'b0;
            alloc_id <= '0;
            state    <= S_EMIT;
          end else begin
            scan <= scan + LW'(1);
          end
        end
        S_SHIFT: begin
          if (sh_cnt != '0) begin
            sh_pend <= 1'b1;
            sh_wdst <= sh_dst;
            sh_dst  <= sh_up ? sh_dst + LW'(1) : sh_dst - LW'(1);
            sh_cnt  <= sh_cnt - (LW+1)'(1);
          end else begin
            sh_pend <= 1'b0;
            if (!sh_pend) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          e_idx <= e_idx + 2'd1;
          if ({1'b0, e_idx} == n_res - 3'd1) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command descriptor for the current result beat.
  logic signed [12:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic signed [12:0] cx0, cy0, cx1, cy1;

  always_comb begin
    ax0 = 13'(lx);
    ay0 = 13'(ly);
    ax1 = 13'(lx) + $signed({2'b00, lw});
    ay1 = 13'(ly) + $signed({2'b00, lh});
    bx0 = 13'(r_px);
    by0 = 13'(r_py);
    bx1 = 13'(r_px) + $signed({2'b00, lw});
    by1 = 13'(r_py) + $signed({2'b00, lh});
    cx0 = 13'(lx) + 13'(r_ax0);
    cy0 = 13'(ly) + 13'(r_ay0);
    cx1 = 13'(lx) + 13'(r_ax1);
    cy1 = 13'(ly) + 13'(r_ay1);

    desc      = '0;
    desc.kind = lsm_pkg::CMD_ACK;
    desc.lo   = 9'sd0;
    desc.hi   = -9'sd1;
    desc.ok   = plan_ok;
    desc.last = ({1'b0, e_idx} == n_res - 3'd1);
    case (plan)
      P_ALLOC: begin
        desc.kind = lsm_pkg::CMD_ALLOC;
        desc.id   = 8'(alloc_id);
      end
      P_MOVE: begin
        desc.kind = (e_idx[1]) ? lsm_pkg::CMD_REDRAW : lsm_pkg::CMD_REBUILD;
        if (e_idx[0]) begin
          {desc.x0, desc.y0, desc.x1, desc.y1} = {bx0, by0, bx1, by1};
          desc.lo = ht;
          desc.hi = e_idx[1] ? ht : top_height;
        end else begin
          {desc.x0, desc.y0, desc.x1, desc.y1} = {ax0, ay0, ax1, ay1};
          desc.lo = 9'sd0;
          desc.hi = e_idx[1] ? ht - 9'sd1 : top_height;
        end
      end
      P_REPAINT: begin
        desc.kind = lsm_pkg::CMD_REDRAW;
        {desc.x0, desc.y0, desc.x1, desc.y1} = {cx0, cy0, cx1, cy1};
        desc.lo = ht;
        desc.hi = ht;
      end
      P_LOWER, P_HIDE, P_RAISE: begin
        desc.kind = e_idx[0] ? lsm_pkg::CMD_REDRAW : lsm_pkg::CMD_REBUILD;
        {desc.x0, desc.y0, desc.x1, desc.y1} = {ax0, ay0, ax1, ay1};
        if (plan == P_LOWER) begin
          desc.lo = hnew + 9'sd1;
          desc.hi = e_idx[0] ? ht : top_height;
        end else if (plan == P_HIDE) begin
          desc.lo = 9'sd0;
          desc.hi = e_idx[0] ? ht - 9'sd1 : top_height;
        end else begin
          desc.lo = hnew;
          desc.hi = e_idx[0] ? hnew : top_height;
        end
      end
      default: begin
      end
    endcase
  end

  lsm_layer_mem #(
    .DEPTH(MAX_LAYERS),
    .AW   (LW)
  ) u_layer_mem (
    .clk  (clk),
    .we   (lm_we),
    .waddr(lm_waddr),
    .wdata(lm_wdata),
    .raddr(lm_raddr),
    .rdata(lm_rdata)
  );

  lsm_order_mem #(
    .DEPTH(MAX_LAYERS),
    .AW   (LW)
  ) u_order_mem (
    .clk  (clk),
    .we   (om_we),
    .waddr(om_waddr),
    .wdata(om_wdata),
    .raddr(om_raddr),
    .rdata(om_rdata)
  );

  lsm_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .en        (state == S_EMIT),
    .desc      (desc),
    .screen_w  (screen_w),
    .screen_h  (screen_h),
    .strobe    (strobe),
    .cmd_kind  (cmd_kind),
    .rect_x0   (rect_x0),
    .rect_y0   (rect_y0),
    .rect_x1   (rect_x1),
    .rect_y1   (rect_y1),
    .layer_low (layer_low),
    .layer_high(layer_high),
    .layer_out (layer_out),
    .ok        (ok),
    .last      (last)
  );

endmodule

`default_nettype wire

### hdl/lsm_checker.sv
// ----------------------------------------------------------------------------
// lsm_checker
// Port-level checks of the layer stack manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [1:0] cmd_kind,
  input wire logic       ok,
  input wire logic       last
);

  // The results of one request arrive as an unbroken run of beats.
  `LSM_ASSERT(a_run_unbroken, clk, rst, strobe && !last |=> strobe)

  // An accepted request keeps the block busy in the next cycle.
  `LSM_ASSERT(a_accept_busy, clk, rst, start && !busy |=> busy)

  // Acknowledges and allocation answers are always single beats.
  `LSM_ASSERT(a_single_last, clk, rst,
              strobe && (cmd_kind == lsm_pkg::CMD_ACK || cmd_kind == lsm_pkg::CMD_ALLOC) |-> last)

  // Repaint commands are only produced for successful requests.
  `LSM_ASSERT(a_repaint_ok, clk, rst,
              strobe && (cmd_kind == lsm_pkg::CMD_REBUILD || cmd_kind == lsm_pkg::CMD_REDRAW) |-> ok)

  // No result appears out of an idle block without a request.
  `LSM_ASSERT(a_no_spurious, clk, rst, !busy && !strobe |=> !strobe)

endmodule

bind layer_stack_manager_top lsm_checker u_lsm_checker (.*);

`default_nettype wire

### tb/layer_stack_manager_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// layer_stack_manager_top_tb
// Self-checking bench for the layer pool and stacking-order manager. A short
// directed table covers the edge cases. Random request sequences follow
// under several screen sizes. Every result beat is compared field by field
// against the beat of a typed row or a behavioral predictor of the pool,
// the order table and the repaint commands.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_stack_manager_top_tb;

  localparam int LAYERS = 256;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         id;
    logic signed [9:0]  hgt;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [10:0]        sx;
    logic [10:0]        sy;
    logic signed [11:0] ax0;
    logic signed [11:0] ay0;
    logic signed [11:0] ax1;
    logic signed [11:0] ay1;
  } request_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [11:0]       x0;
    logic [11:0]       y0;
    logic [11:0]       x1;
    logic [11:0]       y1;
    logic signed [8:0] lo;
    logic signed [8:0] hi;
    logic [7:0]        id;
    logic              ok;
    logic              last;
  } command_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    command_t cmd;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] req_type = '0;
  logic [7:0] sheet_id = '0;
  logic signed [9:0] new_height = '0;
  logic signed [11:0] pos_x = '0, pos_y = '0;
  logic [10:0] size_x = '0, size_y = '0;
  logic signed [11:0] area_x0 = '0, area_y0 = '0, area_x1 = '0, area_y1 = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic strobe;
  logic [1:0] cmd_kind;
  logic [11:0] rect_x0, rect_y0, rect_x1, rect_y1;
  logic signed [8:0] layer_low, layer_high;
  logic [7:0] layer_out;
  logic ok, last;

  layer_stack_manager_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .sheet_id(sheet_id), .new_height(new_height),
    .pos_x(pos_x), .pos_y(pos_y), .size_x(size_x), .size_y(size_y),
    .area_x0(area_x0), .area_y0(area_y0), .area_x1(area_x1), .area_y1(area_y1),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .cmd_kind(cmd_kind),
    .rect_x0(rect_x0), .rect_y0(rect_y0), .rect_x1(rect_x1), .rect_y1(rect_y1),
    .layer_low(layer_low), .layer_high(layer_high), .layer_out(layer_out),
    .ok(ok), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state.
  bit used_flag [LAYERS];
  int stack_pos [LAYERS];
  int stack_map [LAYERS];
  int top_level;
  int org_x [LAYERS], org_y [LAYERS], ext_w [LAYERS], ext_h [LAYERS];
  int scr_w, scr_h;

  command_t pending_cmds [$];
  command_t step_cmds [$];
  int fail_count = 0;
  bit idle_on = 1'b1;

  function automatic int slot(int k);
    return (k < 0 || k >= LAYERS) ? 0 : k;
  endfunction

  function automatic int clip(int v, int lim);
    if (v < 0) return 0;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void add_cmd(logic [1:0] kind, int x0, int y0, int x1, int y1,
                                  int lo, int hi, int id, bit okv);
    command_t c;
    int cx0, cy0, cx1, cy1;
    cx0 = 0; cy0 = 0; cx1 = 0; cy1 = 0;
    if (kind == lsm_pkg::CMD_REBUILD || kind == lsm_pkg::CMD_REDRAW) begin
      cx0 = clip(x0, scr_w);
      cy0 = clip(y0, scr_h);
      cx1 = clip(x1, scr_w);
      cy1 = clip(y1, scr_h);
      if (cx1 < cx0) cx1 = cx0;
      if (cy1 < cy0) cy1 = cy0;
    end
    c.kind = kind;
    c.x0 = cx0[11:0];
    c.y0 = cy0[11:0];
    c.x1 = cx1[11:0];
    c.y1 = cy1[11:0];
    c.lo = lo[8:0];
    c.hi = hi[8:0];
    c.id = id[7:0];
    c.ok = okv;
    c.last = 1'b0;
    step_cmds.push_back(c);
  endfunction

  function automatic void place(int h, int id);
    stack_map[slot(h)] = id;
    stack_pos[id] = h;
  endfunction

  function automatic void restack(int id, int req);
    int old, lim, h, k, x0, y0, x1, y1;
    old = stack_pos[id];
    lim = (old >= 0) ? top_level : top_level + 1;
    h = req;
    x0 = org_x[id];
    y0 = org_y[id];
    x1 = x0 + ext_w[id];
    y1 = y0 + ext_h[id];
    if (h > lim) h = lim;
    if (h < -1) h = -1;
    if (h == old) begin
      add_cmd(lsm_pkg::CMD_ACK, 0, 0, 0, 0, 0, -1, 0, 1'b1);
      return;
    end
    stack_pos[id] = h;
    if (old > h) begin
      if (h >= 0) begin
        for (k = old; k > h; k--) place(k, stack_map[slot(k - 1)]);
        place(h, id);
        add_cmd(lsm_pkg::CMD_REBUILD, x0, y0, x1, y1, h + 1, top_level, 0, 1'b1);
        add_cmd(lsm_pkg::CMD_REDRAW, x0, y0, x1, y1, h + 1, old, 0, 1'b1);
      end else begin
        for (k = old; k < top_level; k++) place(k, stack_map[slot(k + 1)]);
        top_level--;
        add_cmd(lsm_pkg::CMD_REBUILD, x0, y0, x1, y1, 0, top_level, 0, 1'b1);
        add_cmd(lsm_pkg::CMD_REDRAW, x0, y0, x1, y1, 0, old - 1, 0, 1'b1);
      end
    end else begin
      if (old >= 0) begin
        for (k = old; k < h; k++) place(k, stack_map[slot(k + 1)]);
      end else begin
        for (k = top_level; k >= h; k--) place(k + 1, stack_map[slot(k)]);
        top_level++;
      end
      place(h, id);
      add_cmd(lsm_pkg::CMD_REBUILD, x0, y0, x1, y1, h, top_level, 0, 1'b1);
      add_cmd(lsm_pkg::CMD_REDRAW, x0, y0, x1, y1, h, h, 0, 1'b1);
    end
  endfunction

  // Works out the result beats of one request and updates the model state.
  function automatic void predict_request(request_t r);
    int id, i, ht, ox, oy, nx, ny, w, hh;
    id = r.id;
    step_cmds.delete();
    if (r.kind == lsm_pkg::REQ_ALLOC) begin
      for (i = 0; i < LAYERS; i++) begin
        if (!used_flag[i]) break;
      end
      if (i < LAYERS) begin
        used_flag[i] = 1'b1;
        stack_pos[i] = -1;
        add_cmd(lsm_pkg::CMD_ALLOC, 0, 0, 0, 0, 0, -1, i, 1'b1);
      end else begin
        add_cmd(lsm_pkg::CMD_ALLOC, 0, 0, 0, 0, 0, -1, 0, 1'b0);
      end
    end else if (r.kind > lsm_pkg::REQ_FREE || !used_flag[id]) begin
      add_cmd(lsm_pkg::CMD_ACK, 0, 0, 0, 0, 0, -1, 0, 1'b0);
    end else if (r.kind == lsm_pkg::REQ_SIZE) begin
      ext_w[id] = r.sx;
      ext_h[id] = r.sy;
      add_cmd(lsm_pkg::CMD_ACK, 0, 0, 0, 0, 0, -1, 0, 1'b1);
    end else if (r.kind == lsm_pkg::REQ_HEIGHT) begin
      restack(id, int'(r.hgt));
    end else if (r.kind == lsm_pkg::REQ_MOVE) begin
      ox = org_x[id]; oy = org_y[id];
      nx = int'(r.px); ny = int'(r.py);
      w = ext_w[id]; hh = ext_h[id];
      ht = stack_pos[id];
      org_x[id] = nx;
      org_y[id] = ny;
      if (ht >= 0) begin
        add_cmd(lsm_pkg::CMD_REBUILD, ox, oy, ox + w, oy + hh, 0, top_level, 0, 1'b1);
        add_cmd(lsm_pkg::CMD_REBUILD, nx, ny, nx + w, ny + hh, ht, top_level, 0, 1'b1);
        add_cmd(lsm_pkg::CMD_REDRAW, ox, oy, ox + w, oy + hh, 0, ht - 1, 0, 1'b1);
        add_cmd(lsm_pkg::CMD_REDRAW, nx, ny, nx + w, ny + hh, ht, ht, 0, 1'b1);
      end else begin
        add_cmd(lsm_pkg::CMD_ACK, 0, 0, 0, 0, 0, -1, 0, 1'b1);
      end
    end else if (r.kind == lsm_pkg::REQ_REPAINT) begin
      ht = stack_pos[id];
      if (ht >= 0) begin
        add_cmd(lsm_pkg::CMD_REDRAW, org_x[id] + int'(r.ax0), org_y[id] + int'(r.ay0),
                org_x[id] + int'(r.ax1), org_y[id] + int'(r.ay1), ht, ht, 0, 1'b1);
      end else begin
        add_cmd(lsm_pkg::CMD_ACK, 0, 0, 0, 0, 0, -1, 0, 1'b1);
      end
    end else begin
      if (stack_pos[id] >= 0) restack(id, -1);
      else add_cmd(lsm_pkg::CMD_ACK, 0, 0, 0, 0, 0, -1, 0, 1'b1);
      used_flag[id] = 1'b0;
    end
    step_cmds[step_cmds.size() - 1].last = 1'b1;
  endfunction

  task automatic idle_gap();
    if (idle_on) begin
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Presents one request and waits for the beat to be taken. Start stays high
  // afterwards so that back-to-back requests follow without a gap.
  task automatic issue(request_t r, bit typed, command_t typed_cmd);
    idle_gap();
    start <= 1'b1;
    req_type <= r.kind;
    sheet_id <= r.id;
    new_height <= r.hgt;
    pos_x <= r.px;
    pos_y <= r.py;
    size_x <= r.sx;
    size_y <= r.sy;
    area_x0 <= r.ax0;
    area_y0 <= r.ay0;
    area_x1 <= r.ax1;
    area_y1 <= r.ay1;
    do @(posedge clk); while (busy);
    predict_request(r);
    if (typed) begin
      if (step_cmds.size() != 1) begin
        $error("directed row: %0d results predicted for a single-beat case",
               step_cmds.size());
        fail_count++;
      end
      pending_cmds.push_back(typed_cmd);
    end else begin
      foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_cmds.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [lsm_pkg::CFG_IDX_W-1:0] idx, int value);
    repeat ($urandom_range(3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[11:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lsm_pkg::CFG_SCREEN_W) scr_w = value;
    else scr_h = value;
  endtask

  function automatic int pick_layer();
    int id;
    id = $urandom_range(LAYERS - 1);
    if ($urandom_range(99) < 85) begin
      for (int i = 0; i < 64 && !used_flag[id]; i++) id = $urandom_range(LAYERS - 1);
    end
    return id;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int sel;
    r = request_t'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 10) r.kind = lsm_pkg::REQ_ALLOC;
    else if (sel < 22) r.kind = lsm_pkg::REQ_SIZE;
    else if (sel < 52) r.kind = lsm_pkg::REQ_HEIGHT;
    else if (sel < 67) r.kind = lsm_pkg::REQ_MOVE;
    else if (sel < 82) r.kind = lsm_pkg::REQ_REPAINT;
    else if (sel < 94) r.kind = lsm_pkg::REQ_FREE;
    else r.kind = 3'($urandom_range(6, 7));
    r.id = 8'(pick_layer());
    // Mostly heights in reach of the stack, sometimes anything the port takes.
    if ($urandom_range(99) < 85) r.hgt = 10'($urandom_range(top_level + 2) - 1);
    if ($urandom_range(99) < 70) begin
      r.sx = 11'($urandom_range(400));
      r.sy = 11'($urandom_range(400));
      r.px = 12'($urandom_range(600) - 100);
      r.py = 12'($urandom_range(600) - 100);
      r.ax0 = 12'($urandom_range(100) - 20);
      r.ay0 = 12'($urandom_range(100) - 20);
      r.ax1 = 12'($urandom_range(300) - 20);
      r.ay1 = 12'($urandom_range(300) - 20);
    end
    return r;
  endfunction

  function automatic request_t make_req(logic [2:0] kind, int id, int hgt = 0,
                                        int px = 0, int py = 0, int sx = 0,
                                        int sy = 0, int ax0 = 0, int ay0 = 0,
                                        int ax1 = 0, int ay1 = 0);
    request_t r;
    r.kind = kind; r.id = id[7:0]; r.hgt = hgt[9:0];
    r.px = px[11:0]; r.py = py[11:0]; r.sx = sx[10:0]; r.sy = sy[10:0];
    r.ax0 = ax0[11:0]; r.ay0 = ay0[11:0]; r.ax1 = ax1[11:0]; r.ay1 = ay1[11:0];
    return r;
  endfunction

  function automatic command_t single(logic [1:0] kind, int id, bit okv);
    command_t c;
    c = '0;
    c.kind = kind;
    c.hi = -9'sd1;
    c.id = id[7:0];
    c.ok = okv;
    c.last = 1'b1;
    return c;
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    command_t want;
    if (!rst && strobe) begin
      if (pending_cmds.size() == 0) begin
        $error("result beat with no expectation waiting (cmd_kind %0d)", cmd_kind);
        fail_count++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("cmd_kind", want.kind, cmd_kind);
        check_field("rect_x0", want.x0, rect_x0);
        check_field("rect_y0", want.y0, rect_y0);
        check_field("rect_x1", want.x1, rect_x1);
        check_field("rect_y1", want.y1, rect_y1);
        check_field("layer_low", want.lo, layer_low);
        check_field("layer_high", want.hi, layer_high);
        check_field("layer_out", want.id, layer_out);
        check_field("ok", want.ok, ok);
        check_field("last", want.last, last);
      end
    end
  end

  initial begin
    table_row_t rows [$];
    command_t none;
    int widths [4], heights [4];

    none = '0;
    top_level = -1;
    scr_w = lsm_pkg::SCREEN_W_RST;
    scr_h = lsm_pkg::SCREEN_H_RST;
    for (int i = 0; i < LAYERS; i++) begin
      used_flag[i] = 1'b0;
      stack_pos[i] = -1;
      stack_map[i] = 0;
      org_x[i] = 0; org_y[i] = 0; ext_w[i] = 0; ext_h[i] = 0;
    end

    // Directed table; typed rows carry the expected single beat.
    rows.push_back('{make_req(lsm_pkg::REQ_ALLOC, 77), 1'b1,
                     single(lsm_pkg::CMD_ALLOC, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_SIZE, 0, 0, 0, 0, 2047, 2047), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 0, 256), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 0, 5), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_MOVE, 0, 0, -2048, -2048), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_MOVE, 0, 0, 2047, 2047), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_REPAINT, 0, 0, 0, 0, 0, 0,
                              -2048, -2048, 2047, 2047), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_MOVE, 0, 0, 10, 20), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_ALLOC, 255), 1'b1,
                     single(lsm_pkg::CMD_ALLOC, 1, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_MOVE, 1, 0, 50, 60), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_REPAINT, 1, 0, 0, 0, 0, 0, 0, 0, 5, 5), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 1, -1), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 1, -512), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_SIZE, 1, 0, 0, 0, 100, 80), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 1, 511), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 0, 511), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 0, 0), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 0, -1), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 0, 0), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_FREE, 1), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_HEIGHT, 0, -1), 1'b0, none});
    rows.push_back('{make_req(lsm_pkg::REQ_FREE, 0), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b1)});
    rows.push_back('{make_req(lsm_pkg::REQ_SIZE, 5), 1'b1,
                     single(lsm_pkg::CMD_ACK, 0, 1'b0)});
    rows.push_back('{make_req(3'd6, 0), 1'b1, single(lsm_pkg::CMD_ACK, 0, 1'b0)});
    rows.push_back('{make_req(3'd7, 255, 1), 1'b1, single(lsm_pkg::CMD_ACK, 0, 1'b0)});

    widths = '{320, 1, 2048, 0};
    heights = '{200, 1, 2048, 0};
    widths[3] = $urandom_range(1, 2048);
    heights[3] = $urandom_range(1, 2048);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) issue(rows[i].req, rows[i].typed, rows[i].cmd);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      cfg_write(lsm_pkg::CFG_SCREEN_W, widths[phase]);
      cfg_write(lsm_pkg::CFG_SCREEN_H, heights[phase]);
      idle_on = (phase != 1);
      if (phase == 0) begin
        // Fill the pool past capacity so that the last allocations find it full.
        for (int i = 0; i < 258; i++) begin
          issue(make_req(lsm_pkg::REQ_ALLOC, $urandom), 1'b0, none);
        end
      end
      for (int i = 0; i < 40; i++) issue(random_request(), 1'b0, none);
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+hdl
hdl/lsm_pkg.sv
hdl/lsm_order_mem.sv
hdl/lsm_layer_mem.sv
hdl/lsm_emit.sv
hdl/layer_stack_manager_top.sv
hdl/lsm_checker.sv
tb/layer_stack_manager_top_tb.sv
